### sv/dorrb_pkg.sv
// Package: sequencer states and status codes of the record ring store.
package dorrb_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_DROP_CHK,
    S_PFX_RD,
    S_PFX_CAP,
    S_PUT_PFX,
    S_PUT_BYTE,
    S_DATA_RD,
    S_DATA_CAP,
    S_DONE
  } state_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;
  localparam logic [1:0] ST_NO_REC  = 2'd3;

  localparam int LW = 12;  // record length and byte count width

endpackage

### sv/drop_oldest_record_ring_buffer_top.sv
// Top level: length-prefixed record ring store that drops its oldest records when full.
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall   cmd, wr_first, wr_len, wr_byte
// out      out  out_valid / out_stall rd_byte, rd_last, status, dropped_records, fill_level
//
// One item at a time through a single-port-write, single-port-read byte memory.
// A write into an open record stores one byte; an empty read, orphan byte or reject
// only sets its status; a read returns one byte, first reading the length prefix if it
// opens a record. A record open drops oldest records while it does not fit (a partly
// read one by skipping its unread rest, others by their prefix), then writes prefix and byte.
// Reset clears pointers and counters at once; memory contents are left as they are.
// A new word is taken while a result waits; the sequencer holds at its end until
// the output register is free.
module drop_oldest_record_ring_buffer_top
  import dorrb_pkg::*;
#(
  parameter int BUF_BYTES    = 4096,
  parameter int PREFIX_BYTES = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          cmd,
  input  logic          wr_first,
  input  logic [LW-1:0] wr_len,
  input  logic [7:0]    wr_byte,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    rd_byte,
  output logic          rd_last,
  output logic [1:0]    status,
  output logic [LW-1:0] dropped_records,
  output logic [12:0]   fill_level
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int TW = (AW + 1 > LW + 1) ? AW + 1 : LW + 1;
  localparam int PW = 8 * PREFIX_BYTES;
  localparam int KW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  state_t state, state_next;

  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   fill;
  logic [AW-1:0] committed;
  logic [LW-1:0] wrem, rrem;

  logic          l_cmd, l_first;
  logic [LW-1:0] l_len;
  logic [7:0]    l_byte;
  logic          for_drop, opening;
  logic [KW-1:0] kcnt;
  logic [PW-1:0] acc;

  logic [7:0]    res_rd;
  logic          res_last;
  logic [1:0]    res_status;
  logic [LW-1:0] res_drop;

  logic [TW-1:0] total, free_t, cons_n;
  logic [AW:0]   cons_c, rsum, rptr_cons_w;
  logic [AW-1:0] rptr_cons;
  logic          reject, need_drop, k_last;
  logic [PW-1:0] acc_full;
  logic [LW-1:0] pfx_val, wrem_new;
  logic [AW:0]   raddr_sum;

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == AW'(BUF_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign total     = TW'(PREFIX_BYTES) + TW'(l_len);
  assign free_t    = TW'((AW + 1)'(BUF_BYTES) - fill);
  assign need_drop = (free_t < total) && (committed != '0);
  assign reject    = (l_len == '0) || ((32'(l_len) >> PW) != 32'd0)
                     || (total > TW'(BUF_BYTES));
  assign k_last    = (kcnt == KW'(PREFIX_BYTES - 1));
  assign acc_full  = acc | (PW'(rdata) << (8 * kcnt));
  assign pfx_val   = LW'(acc_full);
  assign wrem_new  = opening ? l_len - 1'b1 : wrem - 1'b1;

  // consume amount, clamped to what the store holds
  always_comb begin
    cons_n = TW'(1);
    unique case (state)
      S_DROP_CHK: cons_n = TW'(rrem);
      S_PFX_CAP:  cons_n = for_drop ? TW'(PREFIX_BYTES) + TW'(pfx_val)
                                    : TW'(PREFIX_BYTES);
      default:    cons_n = TW'(1);
    endcase
  end
  assign cons_c      = (cons_n > TW'(fill)) ? fill : cons_n[AW:0];
  assign rsum        = {1'b0, rptr} + cons_c;
  assign rptr_cons_w = (rsum >= (AW + 1)'(BUF_BYTES)) ? rsum - (AW + 1)'(BUF_BYTES) : rsum;
  assign rptr_cons   = rptr_cons_w[AW-1:0];

  assign raddr_sum = {1'b0, rptr} + (AW + 1)'(kcnt);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        if (!l_cmd) begin
          if (wrem == '0 && l_first) state_next = reject ? S_DONE : S_DROP_CHK;
          else if (wrem != '0)       state_next = S_PUT_BYTE;
          else                       state_next = S_DONE;
        end else begin
          if (rrem == '0 && committed == '0) state_next = S_DONE;
          else if (rrem == '0)               state_next = S_PFX_RD;
          else                               state_next = S_DATA_RD;
        end
      end
      S_DROP_CHK: begin
        if (need_drop) state_next = (rrem != '0) ? S_DROP_CHK : S_PFX_RD;
        else           state_next = S_PUT_PFX;
      end
      S_PFX_RD:  state_next = S_PFX_CAP;
      S_PFX_CAP: begin
        if (!k_last)       state_next = S_PFX_RD;
        else if (for_drop) state_next = S_DROP_CHK;
        else               state_next = S_DATA_RD;
      end
      S_PUT_PFX:  if (k_last) state_next = S_PUT_BYTE;
      S_PUT_BYTE: state_next = S_DONE;
      S_DATA_RD:  state_next = S_DATA_CAP;
      S_DATA_CAP: state_next = S_DONE;
      S_DONE:     if (!out_valid || !out_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr;
    mem_wdata = l_byte;
    mem_raddr = rptr;
    unique case (state)
      S_PUT_PFX: begin
        mem_we    = 1'b1;
        mem_wdata = 8'(32'(l_len) >> (8 * kcnt));
      end
      S_PUT_BYTE: mem_we = 1'b1;
      S_PFX_RD: mem_raddr = (raddr_sum >= (AW + 1)'(BUF_BYTES))
                            ? AW'(raddr_sum - (AW + 1)'(BUF_BYTES)) : AW'(raddr_sum);
      default: mem_raddr = rptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wptr      <= '0;
      rptr      <= '0;
      fill      <= '0;
      committed <= '0;
      wrem      <= '0;
      rrem      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            l_cmd      <= cmd;
            l_first    <= wr_first;
            l_len      <= wr_len;
            l_byte     <= wr_byte;
            res_rd     <= '0;
            res_last   <= 1'b0;
            res_status <= ST_OK;
            res_drop   <= '0;
            opening    <= 1'b0;
            kcnt       <= '0;
            acc        <= '0;
          end
        end
        S_EVAL: begin
          kcnt <= '0;
          acc  <= '0;
          if (!l_cmd) begin
            if (wrem == '0 && l_first) begin
              if (reject) res_status <= ST_TOO_BIG;
              opening <= 1'b1;
            end else if (wrem == '0) begin
              res_status <= ST_NO_REC;
            end
          end else begin
            for_drop <= 1'b0;
            if (rrem == '0 && committed == '0) res_status <= ST_EMPTY;
          end
        end
        S_DROP_CHK: begin
          kcnt     <= '0;
          acc      <= '0;
          for_drop <= 1'b1;
          if (need_drop && rrem != '0) begin
            // drop the unread rest of the record being popped
            rptr      <= rptr_cons;
            fill      <= fill - cons_c;
            rrem      <= '0;
            committed <= committed - 1'b1;
            res_drop  <= res_drop + 1'b1;
          end
        end
        S_PFX_RD: ;
        S_PFX_CAP: begin
          acc  <= acc_full;
          kcnt <= kcnt + 1'b1;
          if (k_last) begin
            rptr <= rptr_cons;
            fill <= fill - cons_c;
            if (for_drop) begin
              committed <= committed - 1'b1;
              res_drop  <= res_drop + 1'b1;
            end else begin
              rrem <= (pfx_val == '0) ? LW'(1) : pfx_val;
            end
          end
        end
        S_PUT_PFX: begin
          wptr <= inc_ptr(wptr);
          fill <= fill + 1'b1;
          kcnt <= kcnt + 1'b1;
        end
        S_PUT_BYTE: begin
          wptr <= inc_ptr(wptr);
          fill <= fill + 1'b1;
          wrem <= wrem_new;
          if (wrem_new == '0) committed <= committed + 1'b1;
        end
        S_DATA_RD: ;
        S_DATA_CAP: begin
          res_rd <= rdata;
          rptr   <= rptr_cons;
          fill   <= fill - cons_c;
          rrem   <= rrem - 1'b1;
          if (rrem == LW'(1)) begin
            res_last  <= 1'b1;
            committed <= committed - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            rd_byte         <= res_rd;
            rd_last         <= res_last;
            status          <= res_status;
            dropped_records <= res_drop;
            fill_level      <= 13'(fill);
          end
        end
        default: ;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (AW + 1)'(BUF_BYTES)) else $error("fill beyond store size");

  a_partial_committed: assert property (@(posedge clk) disable iff (rst)
    rrem != '0 |-> committed != '0) else $error("record in progress but none committed");

  // a record being opened holds prefix bytes before its count is set
  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (committed == '0 && wrem == '0 && state != S_PUT_PFX && state != S_PUT_BYTE)
    |-> fill == '0) else $error("bytes held with no record");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_EVAL) else $error("accepted word not evaluated");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("result outside done state");

endmodule
